/* rtl/rrfd_pkg.sv */
// rrfd_pkg: types, constants and helper functions of the receive-ring deframer
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package rrfd_pkg;

   localparam int unsigned RING_BYTES = 32768;

   localparam int BYTE_W     = 8;
   localparam int PTR_W      = 16;
   localparam int LEN_W      = 11;
   localparam int CNT_W      = 11;
   localparam int TYPE_W     = 16;
   localparam int HDR_KEEP_W = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEN_W-1:0]  RST_MIN_FRAME_LEN = 11'd64;
   localparam logic [LEN_W-1:0]  RST_MAX_FRAME_LEN = 11'd1518;
   localparam logic [TYPE_W-1:0] RST_TYPE_A        = 16'h0800;
   localparam logic [TYPE_W-1:0] RST_TYPE_B        = 16'h0806;
   localparam logic [PTR_W-1:0]  ACK_OFFSET        = 16'd16;
   localparam logic [PTR_W-1:0]  ACK_MASK          = 16'hFFFC;
   localparam logic [LEN_W-1:0]  CRC_BYTES         = 11'd4;
   localparam logic [CNT_W-1:0]  TYPE_HI_IDX       = 11'd12;
   localparam logic [CNT_W-1:0]  TYPE_LO_IDX       = 11'd13;
   localparam logic [LEN_W-1:0]  SHORT_PAYLOAD     = 11'd14;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_CONSUMED   = 2'd1,
      KIND_BAD_HEADER = 2'd2,
      KIND_BAD_TYPE   = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_FRAME_LEN = 2'd0,
      CSR_MAX_FRAME_LEN = 2'd1,
      CSR_TYPE_A        = 2'd2,
      CSR_TYPE_B        = 2'd3
   } csr_addr_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     payload_byte;
      logic                  last_payload;
      logic [PTR_W-1:0]      read_pointer;
      logic [PTR_W-1:0]      ack_value;
   } result_type;

   function automatic logic [PTR_W-1:0] ack_of(input logic [PTR_W-1:0] ptr);
      return (ptr - ACK_OFFSET) & ACK_MASK;
   endfunction

   // crc plus pad up to the next 4-byte boundary
   function automatic logic [CNT_W-1:0] skip_count(input logic [1:0] ptr_lo,
                                                   input logic [1:0] len_lo);
      logic [1:0] pad;
      pad = 2'd0 - (ptr_lo + len_lo);
      return CNT_W'(3'd4 + {1'b0, pad});
   endfunction

endpackage

`default_nettype wire

/* rtl/rrfd_if.sv */
// rrfd_if: request, response and register-write channels of the deframer
// depends on rrfd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rrfd_req_if;
   import rrfd_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   ring_byte;
   logic [PTR_W-1:0]    write_pointer;
   modport source (output valid, output ring_byte, output write_pointer, input ready);
   modport sink   (input valid, input ring_byte, input write_pointer, output ready);
endinterface

interface rrfd_rsp_if;
   import rrfd_pkg::*;
   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic                last_payload;
   logic [PTR_W-1:0]    read_pointer;
   logic [PTR_W-1:0]    ack_value;
   modport source (output valid, output kind, output payload_byte, output last_payload,
                   output read_pointer, output ack_value, input ready);
   modport sink   (input valid, input kind, input payload_byte, input last_payload,
                   input read_pointer, input ack_value, output ready);
endinterface

interface rrfd_csr_if;
   import rrfd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/rrfd_parser.sv */
// rrfd_parser: frame state, register file and the per-byte parse logic
// depends on rrfd_pkg and rrfd_if
`timescale 1ns / 1ps
`default_nettype none

module rrfd_parser #(
   parameter int unsigned RING_BYTES = rrfd_pkg::RING_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_fire,
   input  logic [rrfd_pkg::BYTE_W-1:0]  ring_byte,
   input  logic [rrfd_pkg::PTR_W-1:0]   write_pointer,
   rrfd_csr_if.sink                     csr_chan,
   output logic                         res_valid,
   output rrfd_pkg::result_type         res
);
   import rrfd_pkg::*;

   localparam logic [17:0] RING_LIMIT = 18'(RING_BYTES);

   logic [LEN_W-1:0]      min_len_ff, max_len_ff;
   logic [TYPE_W-1:0]     type_a_ff, type_b_ff;

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      bc_ff, bc_in;
   logic [HDR_KEEP_W-1:0] hw_ff, hw_in;
   logic [LEN_W-1:0]      fl_ff, fl_in;
   logic [PTR_W-1:0]      rp_ff, rp_in;
   logic [PTR_W-1:0]      np_ff, np_in;
   logic [BYTE_W-1:0]     thb_ff, thb_in;

   logic [LEN_W-1:0]      copy_len;
   logic [CNT_W:0]        idx_next;
   logic                  pay_last;
   logic                  zero_type_ok;
   logic                  type13_ok;
   logic [31:0]           hdr_word;
   logic [15:0]           hdr_status, hdr_len;
   logic                  hdr_bad;
   logic [17:0]           np_sum, np_wrap;
   kind_type              res_kind;
   logic [BYTE_W-1:0]     res_byte;
   logic                  res_last;
   logic [PTR_W-1:0]      res_ptr;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= RST_MIN_FRAME_LEN;
         max_len_ff <= RST_MAX_FRAME_LEN;
         type_a_ff  <= RST_TYPE_A;
         type_b_ff  <= RST_TYPE_B;
      end else if (csr_chan.valid) begin
         unique case (csr_addr_type'(csr_chan.addr))
            CSR_MIN_FRAME_LEN: min_len_ff <= csr_chan.wdata[LEN_W-1:0];
            CSR_MAX_FRAME_LEN: max_len_ff <= csr_chan.wdata[LEN_W-1:0];
            CSR_TYPE_A:        type_a_ff  <= csr_chan.wdata;
            CSR_TYPE_B:        type_b_ff  <= csr_chan.wdata;
            default:           ;
         endcase
      end
   end

   // payload helpers
   assign copy_len     = (fl_ff >= CRC_BYTES) ? fl_ff - CRC_BYTES : '0;
   assign idx_next     = {1'b0, bc_ff} + 1'b1;
   assign pay_last     = idx_next >= {1'b0, copy_len};
   assign zero_type_ok = (type_a_ff == '0) || (type_b_ff == '0);
   assign type13_ok    = ({thb_ff, ring_byte} == type_a_ff) ||
                         ({thb_ff, ring_byte} == type_b_ff);

   // header helpers: bytes arrive little-endian, the fourth one completes the word
   assign hdr_word   = {8'd0, hw_ff} | ({24'd0, ring_byte} << {bc_ff[1:0], 3'b000});
   assign hdr_status = hdr_word[15:0];
   assign hdr_len    = hdr_word[31:16];
   assign hdr_bad    = !hdr_status[0] || (hdr_len < {5'd0, min_len_ff}) ||
                       (hdr_len > {5'd0, max_len_ff}) || (hdr_len < 16'd4);
   assign np_sum     = ({2'b00, rp_ff} + {7'd0, hdr_len[LEN_W-1:0]} + 18'd7) & ~18'd3;
   assign np_wrap    = (np_sum >= RING_LIMIT) ? np_sum - RING_LIMIT : np_sum;

   always_comb begin
      phase_in  = phase_ff;
      bc_in     = bc_ff;
      hw_in     = hw_ff;
      fl_in     = fl_ff;
      rp_in     = rp_ff;
      np_in     = np_ff;
      thb_in    = thb_ff;
      res_valid = 1'b0;
      res_kind  = KIND_PAYLOAD;
      res_byte  = '0;
      res_last  = 1'b0;
      res_ptr   = rp_ff;
      case (phase_ff)
         PH_PAYLOAD: begin
            bc_in = idx_next[CNT_W-1:0];
            if (bc_ff == TYPE_HI_IDX) begin
               thb_in = ring_byte;
            end
            if (((bc_ff == TYPE_LO_IDX) && !type13_ok) ||
                (pay_last && (copy_len < SHORT_PAYLOAD) && !zero_type_ok)) begin
               rp_in     = write_pointer;
               phase_in  = PH_HEADER;
               bc_in     = '0;
               hw_in     = '0;
               res_valid = 1'b1;
               res_kind  = KIND_BAD_TYPE;
               res_ptr   = write_pointer;
            end else begin
               if (pay_last) begin
                  phase_in = PH_SKIP;
                  bc_in    = skip_count(rp_ff[1:0], fl_ff[1:0]);
               end
               res_valid = 1'b1;
               res_byte  = ring_byte;
               res_last  = pay_last;
            end
         end
         PH_SKIP: begin
            if (bc_ff <= 11'd1) begin
               rp_in     = np_ff;
               phase_in  = PH_HEADER;
               bc_in     = '0;
               res_valid = 1'b1;
               res_kind  = KIND_CONSUMED;
               res_ptr   = np_ff;
            end else begin
               bc_in = bc_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            if (bc_ff[1:0] != 2'd3) begin
               hw_in = hdr_word[HDR_KEEP_W-1:0];
               bc_in = CNT_W'(bc_ff[1:0]) + 1'b1;
            end else begin
               hw_in = '0;
               bc_in = '0;
               if (hdr_bad) begin
                  rp_in     = write_pointer;
                  res_valid = 1'b1;
                  res_kind  = KIND_BAD_HEADER;
                  res_ptr   = write_pointer;
               end else begin
                  fl_in  = hdr_len[LEN_W-1:0];
                  np_in  = np_wrap[PTR_W-1:0];
                  thb_in = '0;
                  if (hdr_len[LEN_W-1:0] == CRC_BYTES) begin
                     // empty payload: the ethertype check happens here
                     if (!zero_type_ok) begin
                        rp_in     = write_pointer;
                        res_valid = 1'b1;
                        res_kind  = KIND_BAD_TYPE;
                        res_ptr   = write_pointer;
                     end else begin
                        phase_in = PH_SKIP;
                        bc_in    = skip_count(rp_ff[1:0], hdr_len[1:0]);
                     end
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
      endcase
   end

   assign res.kind         = res_kind;
   assign res.payload_byte = res_byte;
   assign res.last_payload = res_last;
   assign res.read_pointer = res_ptr;
   assign res.ack_value    = ack_of(res_ptr);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         bc_ff    <= '0;
         hw_ff    <= '0;
         fl_ff    <= '0;
         rp_ff    <= '0;
         np_ff    <= '0;
         thb_ff   <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         hw_ff    <= hw_in;
         fl_ff    <= fl_in;
         rp_ff    <= rp_in;
         np_ff    <= np_in;
         thb_ff   <= thb_in;
      end
   end

`ifndef SYNTHESIS
   a_skip_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> (bc_ff != '0) && (bc_ff <= 11'd7))
      else $error("skip count out of range");

   a_header_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> bc_ff <= 11'd3)
      else $error("header byte count out of range");

   a_payload_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      (req_fire && res_valid && res_kind == KIND_PAYLOAD) |-> phase_ff == PH_PAYLOAD)
      else $error("payload result outside payload phase");

   a_consume_moves_pointer: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_SKIP && bc_ff <= 11'd1) |=>
         (phase_ff == PH_HEADER) && (rp_ff == $past(np_ff)))
      else $error("frame end did not advance read pointer");
`endif

endmodule

`default_nettype wire

/* rtl/rrfd_out_reg.sv */
// rrfd_out_reg: response register between the parse logic and the response channel
// depends on rrfd_pkg and rrfd_if
`timescale 1ns / 1ps
`default_nettype none

module rrfd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rrfd_pkg::result_type  data_in,
   output logic                  in_ready,
   rrfd_rsp_if.source            rsp_chan
);
   import rrfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // free now, or emptied by the receiver in this cycle
   assign in_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.kind         = data_ff.kind;
   assign rsp_chan.payload_byte = data_ff.payload_byte;
   assign rsp_chan.last_payload = data_ff.last_payload;
   assign rsp_chan.read_pointer = data_ff.read_pointer;
   assign rsp_chan.ack_value    = data_ff.ack_value;

endmodule

`default_nettype wire

/* rtl/rx_ring_frame_deframer_core.sv */
// Receive-ring frame deframer, top level.
// Channels: req_chan takes one ring byte per request together with the current
// hardware write pointer; rsp_chan returns payload bytes, frame-consumed and
// frame-dropped notices with the new read pointer and its acknowledge value;
// csr_chan writes the length limits and the two accepted ethertypes.
// Each request is parsed in the cycle it is taken and its response, if it has
// one, is shown on rsp_chan on the next cycle. Header, crc and pad bytes give
// no response unless they end or drop a frame. One request is taken per cycle
// while responses are taken, set by the single response register: a new request is
// taken when no response is held or the held one is taken in the same cycle.
// When the receiver stalls with a response held, req_chan.ready drops until
// that response is taken; responses are never lost or repeated.
// Reset (synchronous, active high) returns to the header phase with the read
// pointer at zero and the registers at their defaults; csr_chan is always
// ready. Registers should only be written while no frame is in progress.
// Depends on rrfd_pkg, rrfd_if, rrfd_parser and rrfd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module rx_ring_frame_deframer_core #(
   parameter int unsigned RING_BYTES = rrfd_pkg::RING_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   rrfd_req_if.sink   req_chan,
   rrfd_rsp_if.source rsp_chan,
   rrfd_csr_if.sink   csr_chan
);
   import rrfd_pkg::*;

   logic       out_ready;
   logic       req_fire;
   logic       res_valid;
   result_type res;

   assign req_chan.ready = out_ready;
   assign req_fire       = req_chan.valid && out_ready;

   rrfd_parser #(
      .RING_BYTES (RING_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .ring_byte     (req_chan.ring_byte),
      .write_pointer (req_chan.write_pointer),
      .csr_chan      (csr_chan),
      .res_valid     (res_valid),
      .res           (res)
   );

   rrfd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire && res_valid),
      .data_in  (res),
      .in_ready (out_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
